// File: sv/qtp_pkg.sv
// Package for the quintic trajectory point evaluator: widths, pipeline stage
// numbering, register indexes and polynomial coefficients.
// No dependencies; imported by quintic_trajectory_point.
package qtp_pkg;

  // Field and fixed-point widths.
  localparam int TICK_WIDTH      = 32;
  localparam int POSITION_WIDTH  = 32;
  localparam int DERIV_WIDTH     = 48;
  localparam int TAU_FRAC_BITS   = 24;
  localparam int TAU_WIDTH       = TAU_FRAC_BITS + 1;
  localparam int DELTA_WIDTH     = POSITION_WIDTH + 1;
  // |goal - start| never exceeds 2^POSITION_WIDTH - 1.
  localparam int DMAG_WIDTH      = POSITION_WIDTH;
  // Largest polynomial magnitude is 180 * 2^F, below 2^(F+8).
  localparam int POLY_WIDTH      = TAU_FRAC_BITS + 9;
  localparam int PMAG_WIDTH      = TAU_FRAC_BITS + 8;
  localparam int PROD_WIDTH      = DMAG_WIDTH + PMAG_WIDTH;
  localparam int RES_WIDTH       = PROD_WIDTH - TAU_FRAC_BITS;
  localparam int SRES_WIDTH      = RES_WIDTH + 1;
  localparam int SUM_WIDTH       =
    ((SRES_WIDTH > POSITION_WIDTH) ? SRES_WIDTH : POSITION_WIDTH) + 1;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TICK = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_TICK   = 1'b1;

  // Result lanes.
  localparam int NUM_LANES = 3;
  localparam int LANE_POS  = 0;
  localparam int LANE_VEL  = 1;
  localparam int LANE_ACC  = 2;

  // Pipeline stages: input, one stage per quotient bit, four power stages,
  // polynomial, sign split, multiply, rounding, negation and output.
  localparam int ST_IN       = 0;
  localparam int ST_DIV_LAST = TAU_FRAC_BITS;
  localparam int ST_POW2     = TAU_FRAC_BITS + 1;
  localparam int ST_POW3     = TAU_FRAC_BITS + 2;
  localparam int ST_POW4     = TAU_FRAC_BITS + 3;
  localparam int ST_POW5     = TAU_FRAC_BITS + 4;
  localparam int ST_POLY     = TAU_FRAC_BITS + 5;
  localparam int ST_SIGN     = TAU_FRAC_BITS + 6;
  localparam int ST_MUL      = TAU_FRAC_BITS + 7;
  localparam int ST_ROUND    = TAU_FRAC_BITS + 8;
  localparam int ST_NEG      = TAU_FRAC_BITS + 9;
  localparam int ST_OUT      = TAU_FRAC_BITS + 10;
  localparam int NUM_STAGES  = TAU_FRAC_BITS + 11;

  // Fixed-point constants.
  localparam logic [TAU_WIDTH-1:0]  TAU_ONE    = {1'b1, {TAU_FRAC_BITS{1'b0}}};
  localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (TAU_FRAC_BITS - 1);

  localparam logic signed [POLY_WIDTH-1:0] C6   = POLY_WIDTH'(6);
  localparam logic signed [POLY_WIDTH-1:0] C10  = POLY_WIDTH'(10);
  localparam logic signed [POLY_WIDTH-1:0] C15  = POLY_WIDTH'(15);
  localparam logic signed [POLY_WIDTH-1:0] C30  = POLY_WIDTH'(30);
  localparam logic signed [POLY_WIDTH-1:0] C60  = POLY_WIDTH'(60);
  localparam logic signed [POLY_WIDTH-1:0] C120 = POLY_WIDTH'(120);
  localparam logic signed [POLY_WIDTH-1:0] C180 = POLY_WIDTH'(180);

  // Saturation bounds of a position, held at the width of the final sum.
  localparam logic signed [SUM_WIDTH-1:0] POS_SUM_MAX =
    {{(SUM_WIDTH - POSITION_WIDTH + 1){1'b0}}, {(POSITION_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] POS_SUM_MIN =
    {{(SUM_WIDTH - POSITION_WIDTH + 1){1'b1}}, {(POSITION_WIDTH - 1){1'b0}}};

  typedef logic [TAU_FRAC_BITS-1:0]     frac_t;
  typedef logic signed [POLY_WIDTH-1:0] poly_t;
  typedef logic [PMAG_WIDTH-1:0]        pmag_t;
  typedef logic [PROD_WIDTH-1:0]        prod_t;
  typedef logic [RES_WIDTH-1:0]         res_t;
  typedef logic signed [SRES_WIDTH-1:0] sres_t;

  // Widens a power of tau to a signed polynomial term; tau of one forces 1.0.
  function automatic poly_t to_poly(input logic one, input frac_t t);
    logic [TAU_WIDTH-1:0] full;
    full = one ? TAU_ONE : {1'b0, t};
    return signed'(POLY_WIDTH'(full));
  endfunction

endpackage

// File: sv/quintic_trajectory_point.sv
// An accepted input transaction passes through every stage in order to its result on
// the output. Throughput: one transaction per cycle while out_ready is high.
// The depth is set by the phase divider, which resolves one quotient bit per
// stage, followed by four chained power multipliers and the scaling stages.
// Synchronous reset clears every stage valid bit and both tick registers.
// Quintic minimum-jerk trajectory point evaluator, depends on qtp_pkg.
module quintic_trajectory_point
  import qtp_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [TICK_WIDTH-1:0]             time_now,
  input  logic signed [POSITION_WIDTH-1:0]  start_position,
  input  logic signed [POSITION_WIDTH-1:0]  goal_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [POSITION_WIDTH-1:0]  position,
  output logic signed [DERIV_WIDTH-1:0]     velocity,
  output logic signed [DERIV_WIDTH-1:0]     acceleration
);

  // Configuration registers.
  logic [TICK_WIDTH-1:0] start_tick;
  logic [TICK_WIDTH-1:0] end_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tick <= '0;
      end_tick   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_TICK: start_tick <= cfg_data[TICK_WIDTH-1:0];
        REG_END_TICK:   end_tick   <= cfg_data[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables. A stage may load when it or any stage
  // after it is empty, or when the output is being taken, so bubbles close up.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
    assign en[i] = out_ready | ~(&vld[NUM_STAGES-1:i]);
  end

  assign in_ready  = en[ST_IN];
  assign out_valid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[ST_IN]) begin
        vld[ST_IN] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Input stage and divider pipeline. Index 0 holds the input stage, index k
  // the partial quotient after k bits.
  logic [TICK_WIDTH-1:0]           div_r     [0:TAU_FRAC_BITS];
  logic [TICK_WIDTH-1:0]           div_den   [0:TAU_FRAC_BITS];
  frac_t                           div_q     [0:TAU_FRAC_BITS];
  logic                            div_one   [0:TAU_FRAC_BITS];
  logic                            div_zero  [0:TAU_FRAC_BITS];
  logic signed [POSITION_WIDTH-1:0] div_start [0:TAU_FRAC_BITS];
  logic signed [DELTA_WIDTH-1:0]   div_delta [0:TAU_FRAC_BITS];

  // Clamp the time to the window; an empty or inverted window gives tau of one.
  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      div_one[0]   <= (end_tick <= start_tick) || (time_now >= end_tick);
      div_zero[0]  <= (time_now <= start_tick);
      div_r[0]     <= time_now - start_tick;
      div_den[0]   <= end_tick - start_tick;
      div_q[0]     <= '0;
      div_start[0] <= start_position;
      div_delta[0] <= DELTA_WIDTH'(goal_position) - DELTA_WIDTH'(start_position);
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k <= TAU_FRAC_BITS; k++) begin : g_div
    logic [TICK_WIDTH:0]   rem2;
    logic [TICK_WIDTH+1:0] diff;
    logic                  take;

    assign rem2 = {div_r[k-1], 1'b0};
    assign diff = {1'b0, rem2} - {2'b00, div_den[k-1]};
    assign take = ~diff[TICK_WIDTH+1];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        div_r[k]     <= take ? diff[TICK_WIDTH-1:0] : rem2[TICK_WIDTH-1:0];
        div_q[k]     <= {div_q[k-1][TAU_FRAC_BITS-2:0], take};
        div_den[k]   <= div_den[k-1];
        div_one[k]   <= div_one[k-1];
        div_zero[k]  <= div_zero[k-1];
        div_start[k] <= div_start[k-1];
        div_delta[k] <= div_delta[k-1];
      end
    end
  end

  // Powers of tau, each product truncated back to the fraction width. A tau
  // of one is carried as a flag and the fraction chain then runs on zero.
  frac_t                            pw_frac;
  logic [2*TAU_FRAC_BITS-1:0]       sq_full;
  logic [2*TAU_FRAC_BITS-1:0]       cu_full;
  logic [2*TAU_FRAC_BITS-1:0]       qu_full;
  logic [2*TAU_FRAC_BITS-1:0]       qn_full;

  frac_t pw2_t1, pw2_t2;
  frac_t pw3_t1, pw3_t2, pw3_t3;
  frac_t pw4_t1, pw4_t2, pw4_t3, pw4_t4;
  frac_t pw5_t1, pw5_t2, pw5_t3, pw5_t4, pw5_t5;
  logic  pw2_one, pw3_one, pw4_one, pw5_one;
  logic signed [POSITION_WIDTH-1:0] pw2_start, pw3_start, pw4_start, pw5_start;
  logic signed [DELTA_WIDTH-1:0]    pw2_delta, pw3_delta, pw4_delta, pw5_delta;

  assign pw_frac = (div_one[ST_DIV_LAST] || div_zero[ST_DIV_LAST]) ? '0
                                                                   : div_q[ST_DIV_LAST];
  assign sq_full = pw_frac * pw_frac;
  assign cu_full = pw2_t2 * pw2_t1;
  assign qu_full = pw3_t3 * pw3_t1;
  assign qn_full = pw4_t4 * pw4_t1;

  always_ff @(posedge clk) begin
    if (en[ST_POW2]) begin
      pw2_t1    <= pw_frac;
      pw2_t2    <= sq_full[2*TAU_FRAC_BITS-1:TAU_FRAC_BITS];
      pw2_one   <= div_one[ST_DIV_LAST];
      pw2_start <= div_start[ST_DIV_LAST];
      pw2_delta <= div_delta[ST_DIV_LAST];
    end
    if (en[ST_POW3]) begin
      pw3_t1    <= pw2_t1;
      pw3_t2    <= pw2_t2;
      pw3_t3    <= cu_full[2*TAU_FRAC_BITS-1:TAU_FRAC_BITS];
      pw3_one   <= pw2_one;
      pw3_start <= pw2_start;
      pw3_delta <= pw2_delta;
    end
    if (en[ST_POW4]) begin
      pw4_t1    <= pw3_t1;
      pw4_t2    <= pw3_t2;
      pw4_t3    <= pw3_t3;
      pw4_t4    <= qu_full[2*TAU_FRAC_BITS-1:TAU_FRAC_BITS];
      pw4_one   <= pw3_one;
      pw4_start <= pw3_start;
      pw4_delta <= pw3_delta;
    end
    if (en[ST_POW5]) begin
      pw5_t1    <= pw4_t1;
      pw5_t2    <= pw4_t2;
      pw5_t3    <= pw4_t3;
      pw5_t4    <= pw4_t4;
      pw5_t5    <= qn_full[2*TAU_FRAC_BITS-1:TAU_FRAC_BITS];
      pw5_one   <= pw4_one;
      pw5_start <= pw4_start;
      pw5_delta <= pw4_delta;
    end
  end

  // Polynomials in tau and the magnitude of the position step.
  poly_t t1s, t2s, t3s, t4s, t5s;
  poly_t poly_c [NUM_LANES];
  logic                          dneg_c;
  logic signed [DELTA_WIDTH-1:0] dabs_c;

  always_comb begin
    t1s = to_poly(pw5_one, pw5_t1);
    t2s = to_poly(pw5_one, pw5_t2);
    t3s = to_poly(pw5_one, pw5_t3);
    t4s = to_poly(pw5_one, pw5_t4);
    t5s = to_poly(pw5_one, pw5_t5);
    poly_c[LANE_POS] = C6 * t5s - C15 * t4s + C10 * t3s;
    poly_c[LANE_VEL] = C30 * t4s - C60 * t3s + C30 * t2s;
    poly_c[LANE_ACC] = C120 * t3s - C180 * t2s + C60 * t1s;
    dneg_c = pw5_delta[DELTA_WIDTH-1];
    dabs_c = dneg_c ? -pw5_delta : pw5_delta;
  end

  poly_t                            pl_poly [NUM_LANES];
  logic [DMAG_WIDTH-1:0]            pl_dmag;
  logic                             pl_dneg;
  logic signed [POSITION_WIDTH-1:0] pl_start;

  always_ff @(posedge clk) begin
    if (en[ST_POLY]) begin
      pl_poly  <= poly_c;
      pl_dmag  <= dabs_c[DMAG_WIDTH-1:0];
      pl_dneg  <= dneg_c;
      pl_start <= pw5_start;
    end
  end

  // Split each polynomial into magnitude and result sign.
  poly_t pabs_c [NUM_LANES];
  logic  pneg_c [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      pneg_c[l] = pl_poly[l][POLY_WIDTH-1];
      pabs_c[l] = pneg_c[l] ? -pl_poly[l] : pl_poly[l];
    end
  end

  pmag_t                            sg_pmag [NUM_LANES];
  logic                             sg_neg  [NUM_LANES];
  logic [DMAG_WIDTH-1:0]            sg_dmag;
  logic signed [POSITION_WIDTH-1:0] sg_start;

  always_ff @(posedge clk) begin
    if (en[ST_SIGN]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        sg_pmag[l] <= pabs_c[l][PMAG_WIDTH-1:0];
        sg_neg[l]  <= pneg_c[l] ^ pl_dneg;
      end
      sg_dmag  <= pl_dmag;
      sg_start <= pl_start;
    end
  end

  // Unsigned products of step and polynomial magnitudes, one per lane.
  prod_t                            ml_prod [NUM_LANES];
  logic                             ml_neg  [NUM_LANES];
  logic signed [POSITION_WIDTH-1:0] ml_start;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        ml_prod[l] <= sg_dmag * sg_pmag[l];
        ml_neg[l]  <= sg_neg[l];
      end
      ml_start <= sg_start;
    end
  end

  // Round to nearest on the magnitude, so ties go away from zero.
  prod_t rnd_c [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      rnd_c[l] = ml_prod[l] + ROUND_HALF;
    end
  end

  res_t                             rd_res [NUM_LANES];
  logic                             rd_neg [NUM_LANES];
  logic signed [POSITION_WIDTH-1:0] rd_start;

  always_ff @(posedge clk) begin
    if (en[ST_ROUND]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rd_res[l] <= rnd_c[l][PROD_WIDTH-1:TAU_FRAC_BITS];
        rd_neg[l] <= ml_neg[l];
      end
      rd_start <= ml_start;
    end
  end

  // Restore the sign.
  sres_t                            ng_res [NUM_LANES];
  logic signed [POSITION_WIDTH-1:0] ng_start;

  always_ff @(posedge clk) begin
    if (en[ST_NEG]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        ng_res[l] <= rd_neg[l] ? -signed'({1'b0, rd_res[l]}) : signed'({1'b0, rd_res[l]});
      end
      ng_start <= rd_start;
    end
  end

  // Output register: add the start position and saturate. The derivative
  // results are narrower than their fields, so they only need sign extension.
  logic signed [SUM_WIDTH-1:0] pos_sum;

  assign pos_sum = SUM_WIDTH'(ng_start) + SUM_WIDTH'(ng_res[LANE_POS]);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      if (pos_sum > POS_SUM_MAX) begin
        position <= POS_SUM_MAX[POSITION_WIDTH-1:0];
      end else if (pos_sum < POS_SUM_MIN) begin
        position <= POS_SUM_MIN[POSITION_WIDTH-1:0];
      end else begin
        position <= pos_sum[POSITION_WIDTH-1:0];
      end
      velocity     <= DERIV_WIDTH'(ng_res[LANE_VEL]);
      acceleration <= DERIV_WIDTH'(ng_res[LANE_ACC]);
    end
  end

  // The divider remainder stays below the divisor for an in-window time.
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    vld[ST_DIV_LAST] && !div_one[ST_DIV_LAST] && !div_zero[ST_DIV_LAST]
      |-> div_r[ST_DIV_LAST] < div_den[ST_DIV_LAST])
    else $error("divider remainder not below divisor");

  // Truncated powers of a phase below one never grow.
  a_powers_fall: assert property (@(posedge clk) disable iff (rst)
    vld[ST_POW5] |-> (pw5_t5 <= pw5_t4) && (pw5_t4 <= pw5_t3)
                     && (pw5_t3 <= pw5_t2) && (pw5_t2 <= pw5_t1))
    else $error("powers of tau out of order");

  // A held stage keeps its transaction.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    vld[ST_MUL] && !en[ST_MUL] |=> vld[ST_MUL])
    else $error("transaction dropped from a stalled stage");

  // An empty input stage always takes a new transaction, even under stall.
  a_bubble_accept: assert property (@(posedge clk) disable iff (rst)
    !vld[ST_IN] |-> in_ready)
    else $error("input refused with an empty input stage");

endmodule
